### hw/rtl/flpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flpq_pkg: shared types for the five-level priority queue
// Payload structs of both channels, the command opcodes and the internal
// command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package flpq_pkg;

  localparam int unsigned NUM_LEVELS = 5;

  typedef enum logic [1:0] {
    OP_SEND     = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_PROMOTE  = 2'd2,
    OP_ANNOUNCE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] sender_id;
    logic [2:0]  level;
    logic [31:0] payload;
    logic [6:0]  pop_count;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] out_sender;
    logic [2:0]  out_level;
    logic [31:0] out_payload;
    logic        last;
  } out_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] sender;
    logic [2:0]  level;
    logic [31:0] payload;
    logic [6:0]  count;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/flpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flpq_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module flpq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/flpq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flpq_front: command intake and classification
// Accepts input transfers, discards sends to a rank that does not exist,
// saturates the announce count and queues commands in a two-entry FIFO.
// ----------------------------------------------------------------------------
module flpq_front #(
  parameter int unsigned MAX_POP = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire flpq_pkg::in_t    in_data,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output flpq_pkg::cmd_t        cmd
);

  flpq_pkg::cmd_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  flpq_pkg::cmd_t cls;
  logic           keep;
  logic           push;
  logic           pop;

  // Classify the incoming item.
  always_comb begin
    cls.op      = flpq_pkg::op_t'(in_data.opcode);
    cls.sender  = in_data.sender_id;
    cls.level   = in_data.level;
    cls.payload = in_data.payload;
    cls.count   = (in_data.pop_count > 7'(MAX_POP)) ? 7'(MAX_POP) : in_data.pop_count;
    keep = !(cls.op == flpq_pkg::OP_SEND &&
             in_data.level >= 3'(flpq_pkg::NUM_LEVELS));
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  // Two-entry command FIFO.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= cls;
        wp_r      <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/flpq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flpq_back: queue storage and command execution
// Holds the five rank FIFOs in one RAM and runs send, purge, promote and
// announce. Purge and promote copy a rank into a scratch RAM and rebuild it.
// ----------------------------------------------------------------------------
module flpq_back #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned SENDER_BITS  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire flpq_pkg::cmd_t cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output flpq_pkg::out_t      out_data
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (SENDER_BITS < 16) ? SENDER_BITS : 16;
  localparam int unsigned PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int unsigned EW = SW + PW;
  localparam int unsigned MD = flpq_pkg::NUM_LEVELS << IW;
  localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);
  localparam logic [2:0] TOP_LV = 3'(flpq_pkg::NUM_LEVELS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_DROP, S_LVL, S_DRAIN, S_FILL, S_POPRD, S_POPWR
  } state_t;

  state_t         st_r;
  flpq_pkg::cmd_t cmd_r;
  logic [2:0]     lv_r;
  logic [FW-1:0]  n_r;
  logic [FW-1:0]  i_r;
  logic [IW-1:0]  rp_r;
  logic [IW-1:0]  pi_r;
  logic           pv_r;
  logic [6:0]     rem_r;
  logic [IW-1:0]  head_r [flpq_pkg::NUM_LEVELS];
  logic [IW-1:0]  tail_r [flpq_pkg::NUM_LEVELS];
  logic [FW-1:0]  fill_r [flpq_pkg::NUM_LEVELS];
  logic           out_valid_r;
  flpq_pkg::out_t out_r;

  logic            mw_e, mr_e, sw_e, sr_e;
  logic [IW+2:0]   mw_a, mr_a;
  logic [IW-1:0]   sw_a, sr_a;
  logic [EW-1:0]   mw_d, sw_d, mrd, srd;
  logic [2:0]      dst;
  logic            match, up, keep, any, free;

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
    return (p == IW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  flpq_ram #(.WIDTH(EW), .DEPTH(MD)) u_main (
    .clk(clk), .we(mw_e), .waddr(mw_a), .wdata(mw_d),
    .re(mr_e), .raddr(mr_a), .rdata(mrd)
  );

  flpq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_scratch (
    .clk(clk), .we(sw_e), .waddr(sw_a), .wdata(sw_d),
    .re(sr_e), .raddr(sr_a), .rdata(srd)
  );

  // Rebuild decisions and occupancy summary.
  always_comb begin
    dst   = lv_r - 3'd1;
    match = (srd[EW-1:PW] == cmd_r.sender[SW-1:0]);
    up    = (cmd_r.op == flpq_pkg::OP_PROMOTE) && match && (fill_r[dst] != FULL);
    keep  = !((cmd_r.op == flpq_pkg::OP_REMOVE) && match);
    any   = 1'b0;
    for (int k = 0; k < flpq_pkg::NUM_LEVELS; k++) begin
      any = any | (fill_r[k] != '0);
    end
    free = !out_valid_r || out_ready;
  end

  // Memory port control.
  always_comb begin
    mw_e = 1'b0;
    mw_a = {lv_r, tail_r[lv_r]};
    mw_d = {SW'(cmd_r.sender), PW'(cmd_r.payload)};
    mr_e = 1'b0;
    mr_a = {lv_r, head_r[lv_r]};
    sw_e = 1'b0;
    sw_a = pi_r;
    sw_d = mrd;
    sr_e = 1'b0;
    sr_a = i_r[IW-1:0];
    unique case (st_r)
      S_SEND: begin
        mw_e = (fill_r[lv_r] != FULL);
      end
      S_DRAIN: begin
        mr_e = (i_r != n_r);
        mr_a = {lv_r, rp_r};
        sw_e = pv_r;
      end
      S_FILL: begin
        sr_e = (i_r != n_r);
        mw_e = pv_r && (up || keep);
        mw_a = up ? {dst, tail_r[dst]} : {lv_r, tail_r[lv_r]};
        mw_d = srd;
      end
      S_POPRD: begin
        mr_e = (rem_r != '0) && (fill_r[lv_r] != '0);
      end
      default: begin
      end
    endcase
  end

  assign cmd_ready = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer, queue pointers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < flpq_pkg::NUM_LEVELS; k++) begin
        head_r[k] <= '0;
        tail_r[k] <= '0;
        fill_r[k] <= '0;
      end
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            rem_r <= cmd.count;
            unique case (cmd.op)
              flpq_pkg::OP_SEND: begin
                lv_r <= cmd.level;
                st_r <= S_SEND;
              end
              flpq_pkg::OP_REMOVE: begin
                lv_r <= 3'd0;
                st_r <= S_LVL;
              end
              flpq_pkg::OP_PROMOTE: begin
                lv_r <= 3'd1;
                st_r <= S_LVL;
              end
              flpq_pkg::OP_ANNOUNCE: begin
                lv_r <= 3'd0;
                st_r <= S_POPRD;
              end
            endcase
          end
        end
        S_SEND: begin
          if (fill_r[lv_r] == FULL) begin
            st_r <= S_DROP;
          end else begin
            tail_r[lv_r] <= inc(tail_r[lv_r]);
            fill_r[lv_r] <= fill_r[lv_r] + 1'b1;
            st_r         <= S_IDLE;
          end
        end
        S_DROP: begin
          if (free) begin
            out_r.kind        <= 1'b1;
            out_r.out_sender  <= 16'(SW'(cmd_r.sender));
            out_r.out_level   <= lv_r;
            out_r.out_payload <= 32'(PW'(cmd_r.payload));
            out_r.last        <= 1'b1;
            out_valid_r       <= 1'b1;
            st_r              <= S_IDLE;
          end
        end
        S_LVL: begin
          // The rank is emptied and then rebuilt from its scratch copy.
          n_r          <= fill_r[lv_r];
          rp_r         <= head_r[lv_r];
          i_r          <= '0;
          pv_r         <= 1'b0;
          fill_r[lv_r] <= '0;
          head_r[lv_r] <= '0;
          tail_r[lv_r] <= '0;
          st_r         <= S_DRAIN;
        end
        S_DRAIN: begin
          if (i_r != n_r) begin
            rp_r <= inc(rp_r);
            i_r  <= i_r + 1'b1;
          end
          pv_r <= (i_r != n_r);
          pi_r <= i_r[IW-1:0];
          if (i_r == n_r && !pv_r) begin
            i_r  <= '0;
            st_r <= S_FILL;
          end
        end
        S_FILL: begin
          if (i_r != n_r) begin
            i_r <= i_r + 1'b1;
          end
          pv_r <= (i_r != n_r);
          if (pv_r) begin
            if (up) begin
              tail_r[dst] <= inc(tail_r[dst]);
              fill_r[dst] <= fill_r[dst] + 1'b1;
            end else if (keep) begin
              tail_r[lv_r] <= inc(tail_r[lv_r]);
              fill_r[lv_r] <= fill_r[lv_r] + 1'b1;
            end
          end
          if (i_r == n_r && !pv_r) begin
            if (lv_r == TOP_LV) begin
              st_r <= S_IDLE;
            end else begin
              lv_r <= lv_r + 3'd1;
              st_r <= S_LVL;
            end
          end
        end
        S_POPRD: begin
          if (rem_r == '0) begin
            st_r <= S_IDLE;
          end else if (fill_r[lv_r] == '0) begin
            if (lv_r == TOP_LV) begin
              st_r <= S_IDLE;
            end else begin
              lv_r <= lv_r + 3'd1;
            end
          end else begin
            rem_r        <= rem_r - 7'd1;
            fill_r[lv_r] <= fill_r[lv_r] - 1'b1;
            if (fill_r[lv_r] == FW'(1)) begin
              head_r[lv_r] <= '0;
              tail_r[lv_r] <= '0;
            end else begin
              head_r[lv_r] <= inc(head_r[lv_r]);
            end
            st_r <= S_POPWR;
          end
        end
        S_POPWR: begin
          if (free) begin
            out_r.kind        <= 1'b0;
            out_r.out_sender  <= 16'(mrd[EW-1:PW]);
            out_r.out_level   <= lv_r;
            out_r.out_payload <= 32'(mrd[PW-1:0]);
            out_r.last        <= (rem_r == '0) || !any;
            out_valid_r       <= 1'b1;
            st_r              <= S_POPRD;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/five_level_priority_queue_purge_promote.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// five_level_priority_queue_purge_promote: strict-priority five-rank queue
// Top level joining the command front end and the execution back end.
// ----------------------------------------------------------------------------
// Commands are taken one at a time by the back end; a two-entry command FIFO
// lets the input side run ahead. A dropped send passes through the S_SEND and
// S_DROP states before its result is registered. An announce pops one entry at
// a time and passes over empty ranks. Remove and promote rebuild each rank
// through a scratch RAM with one access per cycle on each simple dual-port
// memory, first draining the rank into the scratch RAM and then filling it back.
// Results leave through an output register, so a stalled result does not stop
// a new command from being taken in.
module five_level_priority_queue_purge_promote #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned SENDER_BITS  = 16,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned MAX_POP      = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire flpq_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output flpq_pkg::out_t      out_data
);

  logic           cmd_valid;
  logic           cmd_ready;
  flpq_pkg::cmd_t cmd;

  flpq_front #(.MAX_POP(MAX_POP)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  flpq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .SENDER_BITS(SENDER_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

`ifndef NO_ASSERTIONS
  // A full command FIFO always presents a command.
  a_fifo_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> cmd_valid) else $error("command FIFO full but empty");

  // A dropped send is always the only result of its command.
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind) |-> out_data.last) else $error("drop not last");

  // Results only ever name an existing rank.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_level <= 3'd4)) else $error("bad result rank");
`endif

endmodule
`default_nettype wire
